[rtl/lrlc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrlc_pkg
// Shared types, constants and the light duty function for the latching relay
// and light controller.
// ----------------------------------------------------------------------------
package lrlc_pkg;

    localparam int PctW     = 7;
    localparam int HalfW    = 14;
    localparam int PulseW   = 8;
    localparam int DebW     = 8;
    localparam int DutyW    = 10;
    localparam int CountW   = 32;
    localparam int CmdW     = 2;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 14;

    localparam logic [DebW-1:0]  QuietMax  = 8'd255;
    localparam logic [DutyW-1:0] DutyMax   = 10'd1023;
    localparam logic [PctW-1:0]  PctMax    = 7'd100;
    // 1023 / 100 scaled by 2**19, set just above it; exact for every percent up to 100
    localparam logic [22:0]      DutyRecip = 23'd5363589;
    localparam int               DutyShift = 19;

    typedef enum logic [CmdW-1:0] {
        CMD_TICK   = 2'd0,
        CMD_SET    = 2'd1,
        CMD_TOGGLE = 2'd2
    } cmd_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_LIGHT_PERCENT    = 3'd0,
        REG_BLINK_ENABLE     = 3'd1,
        REG_BLINK_HALF       = 3'd2,
        REG_PULSE_LENGTH     = 3'd3,
        REG_DEBOUNCE         = 3'd4,
        REG_LIGHT_ACTIVE_LOW = 3'd5
    } cfg_reg_t;

    // Compare value for a brightness percent: pct*1023/100 truncated,
    // percent clamped at 100, inverted for an active-low light.
    function automatic logic [DutyW-1:0] duty_of(input logic [PctW-1:0] pct,
                                                 input logic active_low);
        logic [PctW-1:0]  p;
        logic [29:0]      prod;
        logic [DutyW-1:0] v;
        p    = (pct > PctMax) ? PctMax : pct;
        prod = {23'd0, p} * {7'd0, DutyRecip};
        v    = prod[DutyShift +: DutyW];
        return active_low ? (DutyMax - v) : v;
    endfunction

endpackage

[rtl/lrlc_debounce.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrlc_debounce
// Debouncer for one button; flags a newly accepted press on a tick.
// ----------------------------------------------------------------------------
module lrlc_debounce
    import lrlc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tick,
    input  logic            level,
    input  logic [DebW-1:0] quiet_limit,
    output logic            press
);

    logic            raw_last_reg, raw_last_next;
    logic            stable_reg, stable_next;
    logic [DebW-1:0] quiet_reg, quiet_next;

    always_comb
    begin
        raw_last_next = raw_last_reg;
        stable_next   = stable_reg;
        quiet_next    = quiet_reg;
        press         = 1'b0;
        if (level != raw_last_reg)
        begin
            raw_last_next = level;
            quiet_next    = '0;
        end
        else if (quiet_reg != QuietMax)
        begin
            quiet_next = quiet_reg + 8'd1;
        end
        // accept the level once it has been quiet long enough
        if ((quiet_next > quiet_limit) && (level != stable_reg))
        begin
            stable_next = level;
            press       = !level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_last_reg <= 1'b1;
            stable_reg   <= 1'b1;
            quiet_reg    <= '0;
        end
        else if (tick)
        begin
            raw_last_reg <= raw_last_next;
            stable_reg   <= stable_next;
            quiet_reg    <= quiet_next;
        end
    end

endmodule

[rtl/latching_relay_light_controller_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latching_relay_light_controller_unit
// Two latching relays with coil pulses, button debounce and a dimmable light.
// ----------------------------------------------------------------------------
// Each request is a 1 ms tick (carrying two raw button levels, 0 = pressed)
// or a command that sets or toggles one relay. The block takes one request
// per clock and returns exactly one result per request, in the next cycle;
// all of the state update and the light duty are worked out in the cycle of
// acceptance and land in the state and result registers. The result
// register lets a new request in while it is being taken; in_stall
// rises only while a result is held by out_stall. Configuration is written
// through cfg_valid/cfg_ready (always ready) and takes effect on the next
// request; write it only while no result is pending. Indexes 6 and 7 are
// ignored. Coil outputs show the pulse still running after the request.
// ----------------------------------------------------------------------------
module latching_relay_light_controller_unit
    import lrlc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [CmdW-1:0]     command,
    input  logic                relay_index,
    input  logic                relay_on,
    input  logic                button1_level,
    input  logic                button2_level,
    // result channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic                relay1_coil_a,
    output logic                relay1_coil_b,
    output logic                relay2_coil_a,
    output logic                relay2_coil_b,
    output logic                relay1_closed,
    output logic                relay2_closed,
    output logic                indicator_led,
    output logic [DutyW-1:0]    light_duty,
    output logic [CountW-1:0]   action_count,
    // configuration write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    // configuration registers
    logic [PctW-1:0]   light_percent_reg;
    logic              blink_enable_reg;
    logic [HalfW-1:0]  blink_half_reg;
    logic [PulseW-1:0] pulse_length_reg;
    logic [DebW-1:0]   debounce_reg;
    logic              light_active_low_reg;

    // relay, pulse and blink state
    logic [1:0]        relay_state_reg, relay_state_next;
    logic [PulseW-1:0] pulse_left_reg [2];
    logic [PulseW-1:0] pulse_left_next [2];
    logic [1:0]        pulse_close_reg, pulse_close_next;
    logic              blink_phase_reg, blink_phase_next;
    logic [HalfW-1:0]  blink_wait_reg, blink_wait_next;
    logic [CountW-1:0] action_counter_reg, action_counter_next;

    // result register
    logic              out_valid_reg;
    logic [1:0]        coil_a_reg, coil_b_reg;
    logic [1:0]        closed_reg;
    logic [DutyW-1:0]  duty_reg;
    logic [CountW-1:0] count_reg;

    logic              in_accept;
    logic              tick_accept;
    logic [1:0]        press;
    logic [1:0]        want;
    logic [1:0]        change;
    logic [PctW-1:0]   duty_pct;
    logic [DutyW-1:0]  duty_next;

    // hold the request side only while a finished result is held
    assign in_stall    = out_valid_reg && out_stall;
    assign in_accept   = in_valid && !in_stall;
    assign tick_accept = in_accept && (command == CMD_TICK);
    assign cfg_ready   = 1'b1;

    lrlc_debounce u_deb1
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick_accept),
        .level       (button1_level),
        .quiet_limit (debounce_reg),
        .press       (press[0])
    );

    lrlc_debounce u_deb2
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick_accept),
        .level       (button2_level),
        .quiet_limit (debounce_reg),
        .press       (press[1])
    );

    // Next state for one request. Ticks advance the pulse and blink timers
    // first; button presses and commands then express a wanted relay state,
    // and any relay that differs from its wanted state changes.
    always_comb
    begin
        relay_state_next = relay_state_reg;
        pulse_close_next = pulse_close_reg;
        blink_phase_next = blink_phase_reg;
        blink_wait_next  = blink_wait_reg;
        pulse_left_next  = pulse_left_reg;
        want             = relay_state_reg;

        if (in_accept)
        begin
            unique case (cmd_t'(command))
                CMD_TICK:
                begin
                    for (int i = 0; i < 2; i++)
                    begin
                        if (pulse_left_reg[i] != '0)
                            pulse_left_next[i] = pulse_left_reg[i] - 8'd1;
                    end
                    if (blink_wait_reg != '0)
                        blink_wait_next = blink_wait_reg - 14'd1;
                    // flip the phase once the wait has run out
                    if (relay_state_reg[0] && blink_enable_reg && (blink_wait_next == '0))
                    begin
                        blink_phase_next = !blink_phase_reg;
                        blink_wait_next  = blink_half_reg;
                    end
                    want = relay_state_reg ^ press;
                end
                CMD_SET:
                    want[relay_index] = relay_on;
                CMD_TOGGLE:
                    want[relay_index] = !relay_state_reg[relay_index];
                default:
                    ;
            endcase
        end

        change = want ^ relay_state_reg;
        for (int i = 0; i < 2; i++)
        begin
            if (change[i])
            begin
                relay_state_next[i] = want[i];
                pulse_left_next[i]  = pulse_length_reg;
                pulse_close_next[i] = want[i];
            end
        end
        // a relay one change restarts the blink right away
        if (change[0])
            blink_wait_next = '0;

        action_counter_next = action_counter_reg
                            + {{(CountW-1){1'b0}}, change[0]}
                            + {{(CountW-1){1'b0}}, change[1]};

        // light follows relay one, gated by the blink phase when blinking
        if (!relay_state_next[0])
            duty_pct = '0;
        else if (!blink_enable_reg || blink_phase_next)
            duty_pct = light_percent_reg;
        else
            duty_pct = '0;
        duty_next = duty_of(duty_pct, light_active_low_reg);
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_percent_reg    <= 7'd50;
            blink_enable_reg     <= 1'b0;
            blink_half_reg       <= 14'd500;
            pulse_length_reg     <= 8'd30;
            debounce_reg         <= 8'd40;
            light_active_low_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LIGHT_PERCENT:    light_percent_reg    <= cfg_data[PctW-1:0];
                REG_BLINK_ENABLE:     blink_enable_reg     <= cfg_data[0];
                REG_BLINK_HALF:       blink_half_reg       <= cfg_data[HalfW-1:0];
                REG_PULSE_LENGTH:     pulse_length_reg     <= cfg_data[PulseW-1:0];
                REG_DEBOUNCE:         debounce_reg         <= cfg_data[DebW-1:0];
                REG_LIGHT_ACTIVE_LOW: light_active_low_reg <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    // state update on every accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relay_state_reg    <= '0;
            pulse_left_reg[0]  <= '0;
            pulse_left_reg[1]  <= '0;
            pulse_close_reg    <= '0;
            blink_phase_reg    <= 1'b1;
            blink_wait_reg     <= '0;
            action_counter_reg <= '0;
        end
        else if (in_accept)
        begin
            relay_state_reg    <= relay_state_next;
            pulse_left_reg     <= pulse_left_next;
            pulse_close_reg    <= pulse_close_next;
            blink_phase_reg    <= blink_phase_next;
            blink_wait_reg     <= blink_wait_next;
            action_counter_reg <= action_counter_next;
        end
    end

    // result register: load on accept, drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            for (int i = 0; i < 2; i++)
            begin
                coil_a_reg[i] <= (pulse_left_next[i] != '0) && pulse_close_next[i];
                coil_b_reg[i] <= (pulse_left_next[i] != '0) && !pulse_close_next[i];
            end
            closed_reg <= relay_state_next;
            duty_reg   <= duty_next;
            count_reg  <= action_counter_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign relay1_coil_a = coil_a_reg[0];
    assign relay1_coil_b = coil_b_reg[0];
    assign relay2_coil_a = coil_a_reg[1];
    assign relay2_coil_b = coil_b_reg[1];
    assign relay1_closed = closed_reg[0];
    assign relay2_closed = closed_reg[1];
    assign indicator_led = closed_reg[1];
    assign light_duty    = duty_reg;
    assign action_count  = count_reg;

endmodule

[rtl/lrlc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrlc_checker
// Port-level checks for the latching relay and light controller.
// ----------------------------------------------------------------------------
module lrlc_checker
    import lrlc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic                relay1_coil_a,
    input logic                relay1_coil_b,
    input logic                relay2_coil_a,
    input logic                relay2_coil_b,
    input logic                relay1_closed,
    input logic [DutyW-1:0]    light_duty
);

    // a held result stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // every accepted request yields a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("no result after accepted request");

    // requests are held back only while a result is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("request stalled with no result held");

    // never drive both coils of one relay
    a_coil_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(relay1_coil_a && relay1_coil_b) && !(relay2_coil_a && relay2_coil_b))
        else $error("both coils of a relay driven");

    // light is fully off while relay one is open
    a_light_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !relay1_closed |-> light_duty == '0 || light_duty == DutyMax)
        else $error("light driven with relay one open");

endmodule

bind latching_relay_light_controller_unit lrlc_checker u_lrlc_checker (.*);
